>>> sv/int_to_ascii_radix_formatter_macros.svh
// Assertion macros shared by the radix formatter modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef INT_TO_ASCII_RADIX_FORMATTER_MACROS_SVH
`define INT_TO_ASCII_RADIX_FORMATTER_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ITARF_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ITARF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/itarf_pkg.sv
// Shared types, format codes and character constants for the radix formatter.
// No dependencies; every module file refers to this package by scoped names.
package itarf_pkg;

   localparam int VALUE_WIDTH = 32;
   // Decimal digits of 2^VALUE_WIDTH - 1: floor(w * log10(2)) + 1.
   localparam int DEC_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int HEX_W = 4 * HEX_DIGITS;
   localparam int DIG_W = 4 * DEC_DIGITS;
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] SLOTS_BIN = CNT_W'(VALUE_WIDTH);
   localparam logic [CNT_W-1:0] SLOTS_HEX = CNT_W'(HEX_DIGITS);
   localparam logic [CNT_W-1:0] SLOTS_DEC = CNT_W'(DEC_DIGITS);

   localparam logic [1:0] FMT_BIN = 2'd0;
   localparam logic [1:0] FMT_SDEC = 2'd1;
   localparam logic [1:0] FMT_UDEC = 2'd2;
   localparam logic [1:0] FMT_HEX = 2'd3;

   localparam logic [6:0] CHAR_ZERO = 7'h30;
   localparam logic [6:0] CHAR_B = 7'h62;
   localparam logic [6:0] CHAR_X = 7'h78;
   localparam logic [6:0] CHAR_MINUS = 7'h2d;
   localparam logic [6:0] HEX_GAP = 7'd39;
   localparam logic [3:0] DIGIT_TEN = 4'd10;
   localparam logic [3:0] BCD_FIVE = 4'd5;
   localparam logic [3:0] BCD_THREE = 4'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam logic [QPTR_W-1:0] QPTR_ONE = QPTR_W'(1);
   localparam logic [1:0] QCOUNT_FULL = 2'(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] func;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic last;
   } rsp_type;

   // Classified work item: digits are left-aligned, most significant first.
   typedef struct packed {
      logic [1:0] fmt;
      logic neg;
      logic [DIG_W-1:0] digits;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> sv/itarf_front.sv
// Front end: accepts a transaction, forms the magnitude and digit string.
// Decimal formats run a bit-serial double-dabble; depends on itarf_pkg.
`include "int_to_ascii_radix_formatter_macros.svh"

module itarf_front (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input itarf_pkg::req_type req_data,
   input itarf_pkg::q_status_type q_status,
   output logic push,
   output itarf_pkg::entry_type push_entry
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CONV = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] fmt_ff, fmt_in;
   logic neg_ff, neg_in;
   logic [itarf_pkg::VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [itarf_pkg::DIG_W-1:0] bcd_ff, bcd_in;
   logic [itarf_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic accept;
   logic [itarf_pkg::VALUE_WIDTH-1:0] val;
   logic [itarf_pkg::VALUE_WIDTH-1:0] val_neg;
   logic [itarf_pkg::DIG_W-1:0] bcd_adj;
   logic [itarf_pkg::HEX_W-1:0] hex_ext;

   assign busy = (state_ff != F_IDLE);
   assign accept = start && !busy;
   assign val = req_data.value[itarf_pkg::VALUE_WIDTH-1:0];
   assign val_neg = ~val + {{(itarf_pkg::VALUE_WIDTH-1){1'b0}}, 1'b1};

   // Add three to every BCD digit of five or more before the shift.
   always_comb begin
      for (int i = 0; i < itarf_pkg::DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= itarf_pkg::BCD_FIVE) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + itarf_pkg::BCD_THREE;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      hex_ext = '0;
      hex_ext[itarf_pkg::VALUE_WIDTH-1:0] = mag_ff;
      push_entry.fmt = fmt_ff;
      push_entry.neg = neg_ff;
      push_entry.digits = '0;
      case (fmt_ff)
         itarf_pkg::FMT_BIN: begin
            push_entry.digits[itarf_pkg::DIG_W-1 -: itarf_pkg::VALUE_WIDTH] = mag_ff;
         end
         itarf_pkg::FMT_HEX: begin
            push_entry.digits[itarf_pkg::DIG_W-1 -: itarf_pkg::HEX_W] = hex_ext;
         end
         default: begin
            push_entry.digits = bcd_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      fmt_in = fmt_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      push = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               fmt_in = req_data.func;
               neg_in = (req_data.func == itarf_pkg::FMT_SDEC) &&
                        val[itarf_pkg::VALUE_WIDTH-1];
               mag_in = neg_in ? val_neg : val;
               bcd_in = '0;
               cnt_in = '0;
               if (req_data.func == itarf_pkg::FMT_SDEC ||
                   req_data.func == itarf_pkg::FMT_UDEC) begin
                  state_in = F_CONV;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_CONV: begin
            bcd_in = {bcd_adj[itarf_pkg::DIG_W-2:0], mag_ff[itarf_pkg::VALUE_WIDTH-1]};
            mag_in = {mag_ff[itarf_pkg::VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + itarf_pkg::CNT_ONE;
            if (cnt_ff == itarf_pkg::CNT_LAST) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_status.full) begin
               push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      fmt_ff <= fmt_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   `ITARF_ASSERT_NEXT(a_conv_runs, state_ff == F_CONV && cnt_ff != itarf_pkg::CNT_LAST, state_ff == F_CONV, "conversion left early")
   `ITARF_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff == F_CONV || state_ff == F_PUSH, "accepted transaction was dropped")

endmodule

>>> sv/itarf_queue.sv
// Two-entry queue of classified work items between the front and back ends.
// Depends on itarf_pkg for the entry type and depth.
`include "int_to_ascii_radix_formatter_macros.svh"

module itarf_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input itarf_pkg::entry_type push_entry,
   input logic pop,
   output itarf_pkg::entry_type head_entry,
   output itarf_pkg::q_status_type q_status
);

   itarf_pkg::entry_type mem_ff [itarf_pkg::QUEUE_DEPTH];
   logic [itarf_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign head_entry = mem_ff[rd_ptr_ff];
   assign q_status.full = (count_ff == itarf_pkg::QCOUNT_FULL);
   assign q_status.empty = (count_ff == 2'd0);

   always_comb begin
      case ({push, pop})
         2'b10: count_in = count_ff + 2'd1;
         2'b01: count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + itarf_pkg::QPTR_ONE;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + itarf_pkg::QPTR_ONE;
         end
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `ITARF_ASSERT_ALWAYS(a_no_push_full, !(push && q_status.full), "push into a full queue")
   `ITARF_ASSERT_ALWAYS(a_no_pop_empty, !(pop && q_status.empty), "pop from an empty queue")

endmodule

>>> sv/itarf_back.sv
// Back end: emits prefix, sign and digits one character per cycle.
// Leading zero digits are skipped silently; depends on itarf_pkg.
`include "int_to_ascii_radix_formatter_macros.svh"

module itarf_back (
   input logic clock,
   input logic reset,
   input itarf_pkg::entry_type head_entry,
   input itarf_pkg::q_status_type q_status,
   output logic pop,
   output logic rsp_valid,
   output itarf_pkg::rsp_type rsp_data
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_PRE0 = 2'd1;
   localparam logic [1:0] PH_PRE1 = 2'd2;
   localparam logic [1:0] PH_DIG = 2'd3;

   logic [1:0] ph_ff, ph_in;
   logic [1:0] fmt_ff, fmt_in;
   logic [itarf_pkg::DIG_W-1:0] dig_ff, dig_in;
   logic [itarf_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic started_ff, started_in;
   logic rsp_valid_ff;
   itarf_pkg::rsp_type rsp_data_ff;

   logic emit;
   itarf_pkg::rsp_type emit_data;
   logic [3:0] top_dig;
   logic [6:0] dig_char;
   logic last_slot;
   logic load;

   assign top_dig = (fmt_ff == itarf_pkg::FMT_BIN) ? {3'b000, dig_ff[itarf_pkg::DIG_W-1]}
                                                  : dig_ff[itarf_pkg::DIG_W-1 -: 4];
   assign dig_char = (top_dig < itarf_pkg::DIGIT_TEN)
                     ? itarf_pkg::CHAR_ZERO + {3'b000, top_dig}
                     : itarf_pkg::CHAR_ZERO + {3'b000, top_dig} + itarf_pkg::HEX_GAP;
   assign last_slot = (rem_ff == itarf_pkg::CNT_ONE);
   // The next item loads in the same cycle that the final digit goes out.
   assign load = !q_status.empty && (ph_ff == PH_IDLE || (ph_ff == PH_DIG && last_slot));
   assign pop = load;

   always_comb begin
      ph_in = ph_ff;
      fmt_in = fmt_ff;
      dig_in = dig_ff;
      rem_in = rem_ff;
      started_in = started_ff;
      emit = 1'b0;
      emit_data.char_code = itarf_pkg::CHAR_ZERO;
      emit_data.last = 1'b0;
      unique case (ph_ff)
         PH_IDLE: begin
         end
         PH_PRE0: begin
            emit = 1'b1;
            ph_in = PH_PRE1;
         end
         PH_PRE1: begin
            emit = 1'b1;
            case (fmt_ff)
               itarf_pkg::FMT_BIN: emit_data.char_code = itarf_pkg::CHAR_B;
               itarf_pkg::FMT_HEX: emit_data.char_code = itarf_pkg::CHAR_X;
               default: emit_data.char_code = itarf_pkg::CHAR_MINUS;
            endcase
            ph_in = PH_DIG;
         end
         PH_DIG: begin
            if (started_ff || top_dig != 4'd0 || last_slot) begin
               emit = 1'b1;
               emit_data.char_code = dig_char;
               emit_data.last = last_slot;
               started_in = 1'b1;
            end
            if (fmt_ff == itarf_pkg::FMT_BIN) begin
               dig_in = {dig_ff[itarf_pkg::DIG_W-2:0], 1'b0};
            end else begin
               dig_in = {dig_ff[itarf_pkg::DIG_W-5:0], 4'b0000};
            end
            rem_in = rem_ff - itarf_pkg::CNT_ONE;
            if (last_slot) begin
               ph_in = PH_IDLE;
            end
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase

      if (load) begin
         fmt_in = head_entry.fmt;
         dig_in = head_entry.digits;
         started_in = 1'b0;
         case (head_entry.fmt)
            itarf_pkg::FMT_BIN: rem_in = itarf_pkg::SLOTS_BIN;
            itarf_pkg::FMT_HEX: rem_in = itarf_pkg::SLOTS_HEX;
            default: rem_in = itarf_pkg::SLOTS_DEC;
         endcase
         if (head_entry.fmt == itarf_pkg::FMT_BIN || head_entry.fmt == itarf_pkg::FMT_HEX) begin
            ph_in = PH_PRE0;
         end else if (head_entry.neg) begin
            ph_in = PH_PRE1;
         end else begin
            ph_in = PH_DIG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         rsp_valid_ff <= emit;
      end
      fmt_ff <= fmt_in;
      dig_ff <= dig_in;
      rem_ff <= rem_in;
      started_ff <= started_in;
      rsp_data_ff <= emit_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `ITARF_ASSERT_NEXT(a_started_holds, ph_ff == PH_DIG && emit && !last_slot, started_ff, "digit run lost its started flag")
   `ITARF_ASSERT_NEXT(a_last_ends, ph_ff == PH_DIG && last_slot && !load, ph_ff == PH_IDLE, "text did not end after last digit")

endmodule

>>> sv/int_to_ascii_radix_formatter.sv
// Radix formatter: with both ends idle, the first character of a binary or hex transaction
// passes the front end's push state, the queue and the back end's output register; a decimal
// one first runs the bit-serial conversion, and skipped leading zero digit slots emit nothing.
// The back end takes one prefix character or digit slot per cycle, so a binary transaction
// occupies it far longer than a hex or decimal one.
// The front end stays busy through the bit-serial decimal conversion until the item is pushed.
// Synchronous reset empties the queue and idles both ends; the receiver cannot stall.
module int_to_ascii_radix_formatter (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input itarf_pkg::req_type req_data,
   output logic rsp_valid,
   output itarf_pkg::rsp_type rsp_data
);

   logic push;
   logic pop;
   itarf_pkg::entry_type push_entry;
   itarf_pkg::entry_type head_entry;
   itarf_pkg::q_status_type q_status;

   itarf_front u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .q_status(q_status),
      .push(push),
      .push_entry(push_entry)
   );

   itarf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .head_entry(head_entry),
      .q_status(q_status)
   );

   itarf_back u_back (
      .clock(clock),
      .reset(reset),
      .head_entry(head_entry),
      .q_status(q_status),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule
